// ----- sv/cbe_pkg.sv -----
// Package with payload types, method codes and the fixed-point fraction width for the easing evaluator.
package cbe_pkg;

  localparam int FRAC_BITS = 16;

  typedef struct packed {
    logic [FRAC_BITS:0] progress;
    logic [6:0]         ctrl1_x;
    logic [6:0]         ctrl1_y;
    logic [6:0]         ctrl2_x;
    logic [6:0]         ctrl2_y;
    logic [FRAC_BITS:0] start_guess;
    logic               guess_valid;
  } cbe_in_t;

  typedef struct packed {
    logic [FRAC_BITS:0] curve_value;
    logic [FRAC_BITS:0] curve_param;
    logic [1:0]         solve_method;
  } cbe_out_t;

  typedef enum logic [1:0] {
    METHOD_NEWTON  = 2'd0,
    METHOD_BISECT  = 2'd1,
    METHOD_EXHAUST = 2'd2
  } method_t;

endpackage

// ----- sv/cubic_bezier_easing_eval.sv -----
// Top level of the cubic Bezier easing evaluator with a shared multiplier and a bit-serial divider.
//
//  channel | ports                 | handshake
//  in      | start, busy, in_item  | accepted when start and not busy
//  out     | done, out_item        | one-cycle strobe, cannot be stalled
//
// busy rises at the accepting edge and stays high through the output load; the result
// strobe follows in the next cycle. The four control values are scaled and loaded in S_CTRL.
// A Newton step runs 11 products through the shared multiplier, a check, a bit-serial
// division of 2*FRAC_BITS+3 quotient bits and an update; a converging step ends at
// its check. A bisection step evaluates and checks the midpoint; Y is evaluated last.
// Reset is synchronous and clears the sequencer and done; the receiver cannot stall.
module cubic_bezier_easing_eval #(
  parameter int NEWTON_STEPS = 4,
  parameter int BISECT_STEPS = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  cbe_pkg::cbe_in_t  in_item,
  output logic            done,
  output cbe_pkg::cbe_out_t out_item
);

  localparam int FRAC_BITS = cbe_pkg::FRAC_BITS;
  localparam int W    = FRAC_BITS + 1;
  localparam int SW   = FRAC_BITS + 5;
  localparam int PW   = 2 * SW;
  localparam int NCW  = $clog2(NEWTON_STEPS + 1);
  localparam int BCW  = $clog2(BISECT_STEPS + 1);
  localparam int DW   = 2 * FRAC_BITS + 3;
  localparam int DCW  = $clog2(DW + 1);
  localparam int CNW  = FRAC_BITS + 8;
  localparam int RSH  = CNW + 7;
  localparam int RW   = RSH - 6;
  localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;
  localparam logic [W-1:0] TOL = W'(((1 << FRAC_BITS) + 500) / 1000);
  localparam logic [RW-1:0] RECIP = RW'(((64'd1 << RSH) + 64'd126) / 64'd127);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CTRL  = 9'b000000010,
    S_EVAL  = 9'b000000100,
    S_NCHK  = 9'b000001000,
    S_DIV   = 9'b000010000,
    S_NUPD  = 9'b000100000,
    S_BCHK  = 9'b001000000,
    S_YOUT  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;
  logic [W-1:0] p, t, lo, hi, s;
  logic [W-1:0] c1x, c2x, c1y, c2y, ca, cb;
  logic [1:0] cidx;
  logic [W-1:0] cnum_hi;
  logic [NCW-1:0] ncnt;
  logic [BCW-1:0] bcnt;
  logic bisect;
  logic yeval;
  logic [3:0] op;
  logic signed [SW-1:0] r_t2, r_u2, r_t3, r_a, r_b, r_ut, r_d1, r_d2, r_d3;
  logic signed [SW-1:0] xval, dxv;
  logic [DW-1:0] rem, quo, dvs;
  logic [DCW-1:0] dcnt;
  logic neg;
  cbe_pkg::method_t method;
  cbe_pkg::cbe_in_t in_q;

  // Rounded control value (byte * 2^F + 63) / 127 by reciprocal multiplication.
  logic [6:0] cbyte;
  always_comb begin
    case (cidx)
      2'd0:    cbyte = in_q.ctrl1_x;
      2'd1:    cbyte = in_q.ctrl2_x;
      2'd2:    cbyte = in_q.ctrl1_y;
      default: cbyte = in_q.ctrl2_y;
    endcase
  end

  // Shared multiplier operands.
  logic signed [SW-1:0] ma, mb;
  logic [W-1:0] tcur, ucur;
  assign tcur = yeval ? s : (bisect ? W'((SW'(lo) + SW'(hi)) >> 1) : t);
  assign ucur = ONE - tcur;

  always_comb begin
    ma = '0;
    mb = '0;
    case (op)
      4'd0: begin ma = SW'(tcur); mb = SW'(tcur); end
      4'd1: begin ma = SW'(ucur); mb = SW'(ucur); end
      4'd2: begin ma = r_t2; mb = SW'(tcur); end
      4'd3: begin ma = r_t2; mb = SW'(ucur); end
      4'd4: begin ma = SW'(tcur); mb = r_u2; end
      4'd5: begin ma = r_a; mb = SW'(cb); end
      4'd6: begin ma = r_b; mb = SW'(ca); end
      4'd7: begin ma = SW'(ucur); mb = SW'(tcur); end
      4'd8: begin ma = r_u2; mb = SW'(ca); end
      4'd9: begin ma = r_ut; mb = SW'(cb) - SW'(ca); end
      default: begin ma = r_t2; mb = SW'(ONE) - SW'(cb); end
    endcase
  end

  // Signed product: magnitude rounded, then sign applied.
  logic [SW-1:0] mag_b;
  logic [PW-1:0] prod;
  logic signed [SW-1:0] mres;
  assign mag_b = mb[SW-1] ? SW'(-mb) : SW'(mb);
  assign prod  = PW'(ma) * PW'(mag_b) + (PW'(1) << (FRAC_BITS - 1));
  assign mres  = mb[SW-1] ? -SW'(prod >> FRAC_BITS) : SW'(prod >> FRAC_BITS);

  logic signed [SW-1:0] xsum, xsat;
  assign xsum = SW'(r_t3 + 3 * r_d1 + 3 * mres);
  assign xsat = xsum[SW-1] ? '0 : (xsum > SW'(ONE) ? SW'(ONE) : xsum);

  assign dxv = SW'(3 * r_d1 + 6 * r_d2 + 3 * r_d3);

  logic signed [SW-1:0] errv, aerr;
  assign errv = xval - SW'(p);
  assign aerr = errv[SW-1] ? -errv : errv;

  logic [DW:0] rtry;
  assign rtry = {1'b0, rem[DW-2:0], quo[DW-1]} - {1'b0, dvs};

  logic signed [DW+1:0] tnew;
  assign tnew = neg ? (DW+2)'(t) + (DW+2)'(quo) : (DW+2)'(t) - (DW+2)'(quo);

  logic [W-1:0] mid;
  assign mid = W'((SW'(lo) + SW'(hi)) >> 1);

  logic [CNW-1:0] cnum;
  logic [CNW+RW-1:0] cprod;
  assign cnum    = (CNW'(cbyte) << FRAC_BITS) + CNW'(63);
  assign cprod   = (CNW+RW)'(cnum) * (CNW+RW)'(RECIP);
  assign cnum_hi = W'(cprod >> RSH);

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      state <= S_IDLE;
    end else begin
      done <= (state == S_DONE);
      case (state)
        S_IDLE: begin
          if (start) begin
            in_q  <= in_item;
            p     <= (in_item.progress > ONE) ? ONE : in_item.progress;
            t     <= in_item.guess_valid ?
                     ((in_item.start_guess > ONE) ? ONE : in_item.start_guess) :
                     ((in_item.progress > ONE) ? ONE : in_item.progress);
            cidx  <= 2'd0;
            state <= S_CTRL;
          end
        end
        S_CTRL: begin
          case (cidx)
            2'd0:    c1x <= cnum_hi;
            2'd1:    c2x <= cnum_hi;
            2'd2:    c1y <= cnum_hi;
            default: c2y <= cnum_hi;
          endcase
          cidx <= cidx + 2'd1;
          if (cidx == 2'd3) begin
            ca <= c1x; cb <= c2x;
            ncnt <= '0; bisect <= 1'b0; yeval <= 1'b0; op <= '0;
            state <= (NEWTON_STEPS > 0) ? S_EVAL : S_BCHK;
            bcnt <= '0;
            lo <= '0; hi <= ONE;
          end
        end
        S_EVAL: begin
          case (op)
            4'd0: r_t2 <= mres;
            4'd1: r_u2 <= mres;
            4'd2: r_t3 <= mres;
            4'd3: r_a  <= mres;
            4'd4: r_b  <= mres;
            4'd5: r_d1 <= mres;
            4'd6: xval <= xsat;
            4'd7: r_ut <= mres;
            4'd8: r_d1 <= mres;
            4'd9: r_d2 <= mres;
            default: r_d3 <= mres;
          endcase
          if (op == 4'd6 && (bisect || yeval)) begin
            op <= '0;
            state <= yeval ? S_DONE : S_BCHK;
          end else if (op == 4'd10) begin
            op <= '0;
            state <= S_NCHK;
          end else begin
            op <= op + 4'd1;
          end
        end
        S_NCHK: begin
          if (aerr < SW'(TOL)) begin
            s <= t; method <= cbe_pkg::METHOD_NEWTON;
            ca <= c1y; cb <= c2y; yeval <= 1'b1; state <= S_EVAL;
          end else if (dxv == '0) begin
            bisect <= 1'b1; state <= S_EVAL;
          end else begin
            neg  <= errv[SW-1] != dxv[SW-1];
            dvs  <= DW'(dxv[SW-1] ? -dxv : dxv);
            quo  <= (DW'(aerr) << FRAC_BITS) + (DW'(dxv[SW-1] ? -dxv : dxv) >> 1);
            rem  <= '0;
            dcnt <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rtry[DW]) begin
            rem <= rtry[DW-1:0] + dvs;
            quo <= {quo[DW-2:0], 1'b0};
          end else begin
            rem <= rtry[DW-1:0];
            quo <= {quo[DW-2:0], 1'b1};
          end
          dcnt <= dcnt + DCW'(1);
          if (dcnt == DCW'(DW - 1)) state <= S_NUPD;
        end
        S_NUPD: begin
          t <= tnew[DW+1] ? '0 : (tnew > (DW+2)'(ONE) ? ONE : W'(tnew));
          ncnt <= ncnt + NCW'(1);
          bisect <= (ncnt == NCW'(NEWTON_STEPS - 1));
          state <= S_EVAL;
        end
        S_BCHK: begin
          if (!bisect) begin
            bisect <= 1'b1;
            state <= S_EVAL;
          end else begin
            if (aerr < SW'(TOL)) begin
              s <= mid; method <= cbe_pkg::METHOD_BISECT;
              ca <= c1y; cb <= c2y; yeval <= 1'b1; state <= S_EVAL;
            end else begin
              if (xval < SW'(p)) lo <= mid; else hi <= mid;
              bcnt <= bcnt + BCW'(1);
              if (bcnt == BCW'(BISECT_STEPS - 1)) begin
                s <= W'((SW'(xval < SW'(p) ? mid : lo) + SW'(xval < SW'(p) ? hi : mid)) >> 1);
                method <= cbe_pkg::METHOD_EXHAUST;
                ca <= c1y; cb <= c2y; yeval <= 1'b1;
              end
              state <= S_EVAL;
            end
          end
        end
        S_DONE: begin
          out_item.curve_value  <= W'(xval);
          out_item.curve_param  <= s;
          out_item.solve_method <= method;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/cbe_checker.sv -----
// Port-level checker for the easing evaluator, bound to the top level.
module cbe_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input cbe_pkg::cbe_out_t out_item
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised after item");
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy high with result strobe");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_method_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_item.solve_method != 2'd3)) else $error("bad method code");
  a_param_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_item.curve_param <= 17'h10000)) else $error("parameter out of range");

endmodule

bind cubic_bezier_easing_eval cbe_checker u_cbe_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .out_item(out_item)
);

// ----- tb/cubic_bezier_easing_eval_chk.sv -----
// Checker for the easing evaluator: predicts each result from the accepted item and compares.
module cubic_bezier_easing_eval_chk (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  cbe_pkg::cbe_in_t  in_item,
  input  logic              done,
  input  cbe_pkg::cbe_out_t out_item,
  output int                errors,
  output int                pending,
  output int                checked,
  output int                method_seen [3]
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FX_ONE = 64'd65536;
  localparam longint FX_TOL = (FX_ONE + 500) / 1000;

  cbe_pkg::cbe_out_t expected_results[$];

  function automatic longint fx_mul(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic longint fx_smul(longint a, longint b);
    if (b < 0) begin
      return -fx_mul(a, -b);
    end
    return fx_mul(a, b);
  endfunction

  function automatic longint unit_clamp(longint v);
    if (v < 0) begin
      return 0;
    end
    if (v > FX_ONE) begin
      return FX_ONE;
    end
    return v;
  endfunction

  function automatic longint ctrl_scale(logic [6:0] b);
    return ((longint'(b) << 16) + 63) / 127;
  endfunction

  function automatic longint curve_at(longint t, longint c1, longint c2);
    longint u;
    longint t2;
    u = FX_ONE - t;
    t2 = fx_mul(t, t);
    return unit_clamp(fx_mul(t2, t) + 3 * fx_mul(fx_mul(t2, u), c2)
                      + 3 * fx_mul(fx_mul(t, fx_mul(u, u)), c1));
  endfunction

  function automatic longint slope_at(longint t, longint c1, longint c2);
    longint u;
    u = FX_ONE - t;
    return 3 * fx_mul(fx_mul(u, u), c1) + 6 * fx_smul(fx_mul(u, t), c2 - c1)
           + 3 * fx_mul(fx_mul(t, t), FX_ONE - c2);
  endfunction

  function automatic longint abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic cbe_pkg::cbe_out_t ease_solve(cbe_pkg::cbe_in_t it);
    cbe_pkg::cbe_out_t r;
    longint p, c1x, c1y, c2x, c2y, t, s, err, dx, ae, ad, d, lo, hi, mid, x;
    cbe_pkg::method_t m;
    bit found;
    p = unit_clamp(longint'(it.progress));
    c1x = ctrl_scale(it.ctrl1_x);
    c1y = ctrl_scale(it.ctrl1_y);
    c2x = ctrl_scale(it.ctrl2_x);
    c2y = ctrl_scale(it.ctrl2_y);
    t = it.guess_valid ? unit_clamp(longint'(it.start_guess)) : p;
    s = 0;
    m = cbe_pkg::METHOD_EXHAUST;
    found = 0;
    for (int i = 0; i < 4; i++) begin
      err = curve_at(t, c1x, c2x) - p;
      if (abs_l(err) < FX_TOL) begin
        s = t;
        m = cbe_pkg::METHOD_NEWTON;
        found = 1;
        break;
      end
      dx = slope_at(t, c1x, c2x);
      if (dx == 0) begin
        break;
      end
      ae = abs_l(err);
      ad = abs_l(dx);
      d = ((ae << 16) + ad / 2) / ad;
      if ((err < 0) != (dx < 0)) begin
        d = -d;
      end
      t = unit_clamp(t - d);
    end
    if (!found) begin
      lo = 0;
      hi = FX_ONE;
      for (int i = 0; i < 24; i++) begin
        mid = (lo + hi) >>> 1;
        x = curve_at(mid, c1x, c2x);
        if (abs_l(x - p) < FX_TOL) begin
          s = mid;
          m = cbe_pkg::METHOD_BISECT;
          found = 1;
          break;
        end
        if (x < p) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
      if (!found) begin
        s = (lo + hi) >>> 1;
      end
    end
    r.curve_value = 17'(curve_at(s, c1y, c2y));
    r.curve_param = 17'(s);
    r.solve_method = m;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on result %0d: %s got %0d expected %0d", checked, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cbe_pkg::cbe_out_t want;
    if (!rst) begin
      if (start && !busy) begin
        expected_results = {expected_results, ease_solve(in_item)};
      end
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected item", 0, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_item.curve_value !== want.curve_value) begin
            report_mismatch("curve_value", out_item.curve_value, want.curve_value);
          end
          if (out_item.curve_param !== want.curve_param) begin
            report_mismatch("curve_param", out_item.curve_param, want.curve_param);
          end
          if (out_item.solve_method !== want.solve_method) begin
            report_mismatch("solve_method", out_item.solve_method, want.solve_method);
          end
          if (want.solve_method <= 2) begin
            method_seen[want.solve_method]++;
          end
          checked++;
        end
      end
      pending = expected_results.size();
    end
  end
endmodule

// ----- tb/cubic_bezier_easing_eval_tb.sv -----
// Testbench top for the easing evaluator: clock, reset, stimulus and verdict.
module cubic_bezier_easing_eval_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic done;
  cbe_pkg::cbe_in_t in_item = '0;
  cbe_pkg::cbe_out_t out_item;
  int errors;
  int pending;
  int checked;
  int method_seen [3];
  int idle_pct;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  cubic_bezier_easing_eval u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_item(in_item), .done(done), .out_item(out_item)
  );

  cubic_bezier_easing_eval_chk u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .done(done), .out_item(out_item), .errors(errors), .pending(pending),
    .checked(checked), .method_seen(method_seen)
  );

  function automatic logic [16:0] unit_value();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1FFFF - 17'($urandom_range(0, 65534));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [6:0] ctrl_byte();
    case ($urandom_range(0, 7))
      0: return 7'd0;
      1: return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic send_item(cbe_pkg::cbe_in_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_item <= it;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  task automatic send_fields(logic [16:0] p, logic [6:0] ax, logic [6:0] ay,
                             logic [6:0] bx, logic [6:0] by, logic [16:0] g, logic gv);
    cbe_pkg::cbe_in_t it;
    it.progress = p;
    it.ctrl1_x = ax;
    it.ctrl1_y = ay;
    it.ctrl2_x = bx;
    it.ctrl2_y = by;
    it.start_guess = g;
    it.guess_valid = gv;
    send_item(it);
  endtask

  initial begin
    cbe_pkg::cbe_in_t it;
    idle_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_fields(17'd0, 7'd0, 7'd0, 7'd127, 7'd127, 17'd0, 1'b0);
    send_fields(17'd65536, 7'd127, 7'd127, 7'd0, 7'd0, 17'd0, 1'b0);
    send_fields(17'h1FFFF, 7'd64, 7'd10, 7'd100, 7'd120, 17'h1FFFF, 1'b1);
    send_fields(17'd32768, 7'd127, 7'd0, 7'd0, 7'd127, 17'd0, 1'b1);
    send_fields(17'd32768, 7'd0, 7'd0, 7'd0, 7'd0, 17'd65536, 1'b1);
    send_fields(17'd100, 7'd127, 7'd127, 7'd127, 7'd127, 17'd0, 1'b1);
    send_fields(17'd65000, 7'd127, 7'd127, 7'd127, 7'd127, 17'd65536, 1'b1);
    send_fields(17'd20000, 7'd127, 7'd50, 7'd0, 7'd90, 17'd65536, 1'b1);
    send_fields(17'd45000, 7'd32, 7'd127, 7'd96, 7'd0, 17'd1, 1'b1);
    send_fields(17'd65536, 7'd0, 7'd127, 7'd127, 7'd0, 17'h10000, 1'b0);
    send_fields(17'd1, 7'd42, 7'd85, 7'd21, 7'd106, 17'd1, 1'b1);
    send_fields(17'd65535, 7'd85, 7'd42, 7'd106, 7'd21, 17'd65535, 1'b1);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 62 : (ph == 2) ? 0 : 37;
      for (int n = 0; n < 125; n++) begin
        it.progress = unit_value();
        it.ctrl1_x = ctrl_byte();
        it.ctrl1_y = ctrl_byte();
        it.ctrl2_x = ctrl_byte();
        it.ctrl2_y = ctrl_byte();
        it.start_guess = unit_value();
        it.guess_valid = 1'($urandom_range(0, 1));
        send_item(it);
      end
    end
    start <= 0;
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (50) @(posedge clk);
    $display("Checked %0d items under several sender gap phases.", checked);
    $display("Endings: %0d Newton, %0d bisection tolerance, %0d bisection exhausted.",
             method_seen[0], method_seen[1], method_seen[2]);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
